// File: rtl/lfust_pkg.sv
`default_nettype none
package lfust_pkg;

  localparam int SLOTS = 16;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int LIM_W = (CNT_W > 5) ? CNT_W : 5;
  localparam int KEY_W = 16;
  localparam int USE_W = 16;
  localparam int SEQ_W = 32;

  localparam logic [USE_W-1:0] USE_MAX = '1;
  localparam logic [SEQ_W-1:0] SEQ_MAX = '1;

  // write command broadcast to the cells; load inserts, otherwise bump the count
  typedef struct packed {
    logic             load;
    logic [KEY_W-1:0] key;
    logic [SEQ_W-1:0] seq;
  } cell_wr_t;

  // victim candidate handed from cell to cell
  typedef struct packed {
    logic             valid;
    logic [USE_W-1:0] uses;
    logic [SEQ_W-1:0] ins;
    logic [KEY_W-1:0] key;
    logic [IDX_W-1:0] idx;
  } cand_t;

  typedef struct packed {
    logic             valid;
    logic             match;
    logic [USE_W-1:0] uses;
  } ent_t;

endpackage
`default_nettype wire

// File: rtl/lfust_cell.sv
`default_nettype none
module lfust_cell (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire logic [lfust_pkg::IDX_W-1:0] idx_i,
  input  wire logic [lfust_pkg::KEY_W-1:0] key_i,
  input  wire                              wr_en,
  input  wire lfust_pkg::cell_wr_t         wr,
  input  wire lfust_pkg::cand_t            cand_i,
  output lfust_pkg::cand_t                 cand_o,
  output lfust_pkg::ent_t                  ent_o
);
  import lfust_pkg::*;

  logic             valid_r;
  logic [KEY_W-1:0] key_r;
  logic [USE_W-1:0] uses_r;
  logic [SEQ_W-1:0] ins_r;
  cand_t            cand_r;
  cand_t            cand_nxt;
  logic             take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (wr_en && wr.load) begin
      valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      if (wr.load) begin
        key_r  <= wr.key;
        uses_r <= USE_W'(1);
        ins_r  <= wr.seq;
      end else if (uses_r != USE_MAX) begin
        uses_r <= uses_r + USE_W'(1);
      end
    end
  end

  // replace the incoming candidate if this entry is a better victim:
  // lower count, then older insert, then lower key
  always_comb begin
    take = valid_r &&
           (!cand_i.valid || (uses_r < cand_i.uses) ||
            ((uses_r == cand_i.uses) &&
             ((ins_r < cand_i.ins) ||
              ((ins_r == cand_i.ins) && (key_r < cand_i.key)))));
    if (take) begin
      cand_nxt.valid = 1'b1;
      cand_nxt.uses  = uses_r;
      cand_nxt.ins   = ins_r;
      cand_nxt.key   = key_r;
      cand_nxt.idx   = idx_i;
    end else begin
      cand_nxt = cand_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_r.valid <= 1'b0;
    end else begin
      cand_r.valid <= cand_nxt.valid;
    end
    cand_r.uses <= cand_nxt.uses;
    cand_r.ins  <= cand_nxt.ins;
    cand_r.key  <= cand_nxt.key;
    cand_r.idx  <= cand_nxt.idx;
  end

  assign cand_o      = cand_r;
  assign ent_o.valid = valid_r;
  assign ent_o.match = valid_r && (key_r == key_i);
  assign ent_o.uses  = uses_r;

endmodule
`default_nettype wire

// File: rtl/lfu_slot_table_fifo_tiebreak.sv
`default_nettype none
// LFU slot table: each key word on the input is looked up in a row of SLOTS
// cells. A hit bumps the entry's use count (saturating at 65535); a miss
// inserts the key into the lowest free cell, or, when slots_in_use cells are
// occupied, replaces the entry with the lowest count (oldest insert, then
// lowest key, breaks ties) and reports what was evicted. A hit or a miss with
// room is accepted, then looked up and written back once the output register
// is free. On a full-table miss the victim candidate ripples through the cell
// chain one cell per cycle before the write-back. A finished result sits
// in the output register while the next word is accepted. cfg_wdata writes
// slots_in_use (0 acts as 1, values above SLOTS act as SLOTS); write it only
// while the block is idle.
module lfu_slot_table_fifo_tiebreak (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        cfg_we,
  input  wire [4:0]  cfg_wdata,     // slots_in_use
  input  wire        in_tvalid,
  output logic       in_tready,
  input  wire [15:0] in_tdata,      // key[15:0]
  output logic       out_tvalid,
  input  wire        out_tready,
  // slot_index[3:0], new_count[19:4], evicted_key[35:20], evicted_count[51:36]
  output logic [55:0] out_tdata,
  output logic [1:0]  out_tuser     // hit[0], evicted[1]
);
  import lfust_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOK = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [4:0]       slots_r;
  logic [KEY_W-1:0] key_r;
  logic [SEQ_W-1:0] seq_r;
  logic [IDX_W-1:0] scan_r, scan_nxt;

  logic             out_valid_r;
  logic             res_hit_r, res_ev_r;
  logic [3:0]       res_slot_r;
  logic [USE_W-1:0] res_cnt_r, res_evc_r;
  logic [KEY_W-1:0] res_evk_r;

  cand_t            cand [SLOTS+1];
  ent_t             ent  [SLOTS];
  logic [SLOTS-1:0] match_v, valid_v, cell_we;
  cell_wr_t         wr;

  logic             hit_any, room, out_free, do_write, res_ev;
  logic [IDX_W-1:0] hit_idx, free_idx, sel_idx;
  logic [USE_W-1:0] hit_uses, new_cnt;
  logic [CNT_W-1:0] used;
  logic [LIM_W-1:0] lim, cfg_ext;
  logic [IDX_W+3:0] slot_ext;

  assign cand[0] = '0;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    lfust_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .idx_i  (IDX_W'(i)),
      .key_i  (key_r),
      .wr_en  (cell_we[i]),
      .wr     (wr),
      .cand_i (cand[i]),
      .cand_o (cand[i+1]),
      .ent_o  (ent[i])
    );
    assign match_v[i] = ent[i].match;
    assign valid_v[i] = ent[i].valid;
    assign cell_we[i] = do_write && (sel_idx == IDX_W'(i));
  end

  always_comb begin
    hit_idx  = '0;
    hit_uses = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (match_v[i]) begin
        hit_idx  = hit_idx | IDX_W'(i);
        hit_uses = hit_uses | ent[i].uses;
      end
    end
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_v[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  assign hit_any = |match_v;
  assign used    = CNT_W'($countones(valid_v));
  assign cfg_ext = LIM_W'(slots_r);

  always_comb begin
    if (cfg_ext == '0) begin
      lim = LIM_W'(1);
    end else if (cfg_ext > LIM_W'(SLOTS)) begin
      lim = LIM_W'(SLOTS);
    end else begin
      lim = cfg_ext;
    end
  end

  assign room     = LIM_W'(used) < lim;
  assign out_free = !out_valid_r || out_tready;
  assign new_cnt  = (hit_uses == USE_MAX) ? USE_MAX : hit_uses + USE_W'(1);

  assign wr.load = !(state_r == S_LOOK && hit_any);
  assign wr.key  = key_r;
  assign wr.seq  = seq_r;

  always_comb begin
    state_nxt = state_r;
    scan_nxt  = scan_r;
    do_write  = 1'b0;
    res_ev    = 1'b0;
    sel_idx   = hit_any ? hit_idx : free_idx;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        if (hit_any || room) begin
          if (out_free) begin
            do_write  = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          scan_nxt  = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        sel_idx = cand[SLOTS].idx;
        res_ev  = 1'b1;
        // hold at the last count until the output register frees up
        if (scan_r == IDX_W'(SLOTS - 1)) begin
          if (out_free) begin
            do_write  = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          scan_nxt = scan_r + IDX_W'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign slot_ext = {4'b0, sel_idx};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      slots_r     <= 5'd16;
      seq_r       <= '0;
      scan_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      scan_r  <= scan_nxt;
      if (cfg_we) begin
        slots_r <= cfg_wdata;
      end
      if (do_write && seq_r != SEQ_MAX) begin
        seq_r <= seq_r + SEQ_W'(1);
      end
      if (do_write) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      key_r <= in_tdata[KEY_W-1:0];
    end
    if (do_write) begin
      res_hit_r  <= !wr.load;
      res_slot_r <= slot_ext[3:0];
      res_cnt_r  <= wr.load ? USE_W'(1) : new_cnt;
      res_ev_r   <= res_ev;
      res_evk_r  <= res_ev ? cand[SLOTS].key : '0;
      res_evc_r  <= res_ev ? cand[SLOTS].uses : '0;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, res_evc_r, res_evk_r, res_cnt_r, res_slot_r};
  assign out_tuser  = {res_ev_r, res_hit_r};

`ifndef SYNTH
  a_match_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match_v))
    else $error("key matches more than one cell");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (cell_we == '0))
    else $error("cell written while idle");

  a_seq_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n |=> (!rst_n || seq_r >= $past(seq_r)))
    else $error("sequence number went backward");

  a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
    (do_write && res_ev) |-> (cand[SLOTS].valid && !hit_any))
    else $error("eviction without a valid victim");
`endif

endmodule
`default_nettype wire
